### rtl/core/adfs_pkg.sv
// Package: shared constants, codes and state type for the adjacency list DFS unit
`timescale 1ns / 1ps
package adfs_pkg;
	localparam int MaxVertices = 64;
	localparam int MaxEdges    = 128;
	localparam int NodeCap     = 2 * MaxEdges;
	localparam int VW          = $clog2(MaxVertices);
	localparam int NW          = $clog2(NodeCap);
	localparam int PW          = NW + 1;
	localparam int NodeW       = VW + PW;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_DFS = 2'd1;
	localparam logic [1:0] REQ_CLR = 2'd2;

	localparam logic [1:0] KIND_OK    = 2'd0;
	localparam logic [1:0] KIND_FULL  = 2'd1;
	localparam logic [1:0] KIND_RANGE = 2'd2;
	localparam logic [1:0] KIND_VISIT = 2'd3;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ADD2 = 8'b0000_0010,
		S_ADD3 = 8'b0000_0100,
		S_HEAD = 8'b0000_1000,
		S_TOP  = 8'b0001_0000,
		S_NODE = 8'b0010_0000,
		S_POP  = 8'b0100_0000,
		S_SPAR = 8'b1000_0000
	} state_t;
endpackage

### rtl/core/adfs_ram.sv
// Generic simple dual port RAM with registered read
`timescale 1ns / 1ps
module adfs_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/adjacency_list_dfs_unit.sv
// Top level: adjacency list graph store with depth first walk
//
// channel  direction  handshake             word
// cmd      in         start & !busy         req_type, vertex_a, vertex_b
// result   out        result_stb (no stall) result_kind, vertex, last
// cfg      in         cfg_we                cfg_data (vertex_count)
//
// Add edge: a head read of each end and one node write each, over the head RAM port.
// Search: a head read for the start vertex and each vertex entered, a node read per list
// node and a stack read per frame closed below the first, paced by the registered RAM reads.
// Reject, clear: answered from idle without leaving it.
// Each visited vertex is held until the next is found so the last one can carry last.
// Reset clears list heads through valid bits; no clearing pass.
`timescale 1ns / 1ps
module adjacency_list_dfs_unit
	import adfs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    req_type,
	input  logic [VW-1:0] vertex_a,
	input  logic [VW-1:0] vertex_b,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_data,
	output logic          result_stb,
	output logic [1:0]    result_kind,
	output logic [VW-1:0] vertex,
	output logic          last
);
	state_t state_q;
	logic [6:0]            vcount_q;
	logic [VW-1:0]         va_q, vb_q, pend_q;
	logic [PW-1:0]         nc_q, top_q;
	logic [MaxVertices-1:0] hvalid_q, visited_q;
	logic [VW:0]           depth_q;
	logic                  hrv_s1;

	logic          h_we, n_we, s_we;
	logic [VW-1:0] h_waddr, h_raddr, s_waddr, s_raddr;
	logic [PW-1:0] h_wdata, h_rdata, s_wdata, s_rdata;
	logic [NW-1:0] n_waddr, n_raddr;
	logic [NodeW-1:0] n_wdata, n_rdata;

	logic [VW:0]   cnt_eff;
	logic          a_bad, b_bad, full;
	logic [PW-1:0] hval, nc1, nc2, top_m1;
	logic [VW:0]   dm1, dm2;
	logic [VW-1:0] w;
	logic [PW-1:0] nx;

	adfs_ram #(.W(PW), .D(MaxVertices)) u_head (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata));
	adfs_ram #(.W(NodeW), .D(NodeCap)) u_node (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata));
	adfs_ram #(.W(PW), .D(MaxVertices)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));

	// range and capacity checks
	assign cnt_eff = (vcount_q > 7'(MaxVertices)) ? (VW+1)'(MaxVertices) : vcount_q[VW:0];
	assign a_bad   = {1'b0, vertex_a} >= cnt_eff;
	assign b_bad   = {1'b0, vertex_b} >= cnt_eff;
	assign full    = (nc_q + PW'(2)) > PW'(NodeCap);
	assign hval    = hrv_s1 ? h_rdata : '0;
	assign nc1     = nc_q + PW'(1);
	assign nc2     = nc_q + PW'(2);
	assign top_m1  = top_q - PW'(1);
	assign dm1     = depth_q - (VW+1)'(1);
	assign dm2     = depth_q - (VW+1)'(2);
	assign w       = n_rdata[NodeW-1:PW];
	assign nx      = n_rdata[PW-1:0];
	assign busy    = (state_q != S_IDLE);

	// memory addressing
	always_comb begin
		h_we    = 1'b0;
		h_waddr = vb_q;
		h_wdata = nc1;
		h_raddr = (req_type == REQ_ADD) ? vertex_b : vertex_a;
		n_we    = 1'b0;
		n_waddr = nc_q[NW-1:0];
		n_wdata = {va_q, hval};
		n_raddr = top_m1[NW-1:0];
		s_we    = 1'b0;
		s_waddr = dm1[VW-1:0];
		s_wdata = nx;
		s_raddr = dm2[VW-1:0];
		unique case (state_q)
			S_ADD2: begin
				h_we    = 1'b1;
				n_we    = 1'b1;
				h_raddr = va_q;
			end
			S_ADD3: begin
				h_we    = 1'b1;
				h_waddr = va_q;
				h_wdata = nc2;
				n_we    = 1'b1;
				n_waddr = nc1[NW-1:0];
				n_wdata = {vb_q, (va_q == vb_q) ? nc1 : hval};
			end
			S_NODE: begin
				h_raddr = w;
				s_we    = !visited_q[w];
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcount_q    <= 7'd8;
			nc_q        <= '0;
			hvalid_q    <= '0;
			visited_q   <= '0;
			depth_q     <= '0;
			hrv_s1      <= 1'b0;
			result_stb  <= 1'b0;
			result_kind <= KIND_OK;
			vertex      <= '0;
			last        <= 1'b0;
			va_q        <= '0;
			vb_q        <= '0;
			pend_q      <= '0;
			top_q       <= '0;
		end else begin
			result_stb <= 1'b0;
			hrv_s1     <= hvalid_q[h_raddr];
			if (cfg_we) begin
				vcount_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						va_q <= vertex_a;
						vb_q <= vertex_b;
						result_kind <= KIND_OK;
						vertex      <= '0;
						last        <= 1'b1;
						case (req_type)
							REQ_ADD: begin
								result_stb <= 1'b1;
								if (a_bad || b_bad) begin
									result_kind <= KIND_RANGE;
								end else if (full) begin
									result_kind <= KIND_FULL;
								end else begin
									result_stb <= 1'b0;
									state_q    <= S_ADD2;
								end
							end
							REQ_DFS: begin
								if (a_bad) begin
									result_stb  <= 1'b1;
									result_kind <= KIND_RANGE;
								end else begin
									visited_q <= MaxVertices'(1) << vertex_a;
									pend_q    <= vertex_a;
									depth_q   <= (VW+1)'(1);
									state_q   <= S_HEAD;
								end
							end
							REQ_CLR: begin
								result_stb <= 1'b1;
								hvalid_q   <= '0;
								visited_q  <= '0;
								nc_q       <= '0;
								depth_q    <= '0;
							end
							default: ;
						endcase
					end
				end
				S_ADD2: begin
					hvalid_q[vb_q] <= 1'b1;
					state_q        <= S_ADD3;
				end
				S_ADD3: begin
					hvalid_q[va_q] <= 1'b1;
					nc_q           <= nc2;
					result_stb     <= 1'b1;
					result_kind    <= KIND_OK;
					vertex         <= '0;
					last           <= 1'b1;
					state_q        <= S_IDLE;
				end
				S_HEAD: begin
					top_q   <= hval;
					state_q <= S_TOP;
				end
				S_TOP: begin
					if (top_q == '0) begin
						if (depth_q == (VW+1)'(1)) begin
							// emit the held vertex as the final word
							result_stb  <= 1'b1;
							result_kind <= KIND_VISIT;
							vertex      <= pend_q;
							last        <= 1'b1;
							depth_q     <= '0;
							state_q     <= S_IDLE;
						end else begin
							depth_q <= dm1;
							state_q <= S_POP;
						end
					end else begin
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					if (!visited_q[w]) begin
						// release the held vertex, hold the new one, push cursor
						result_stb   <= 1'b1;
						result_kind  <= KIND_VISIT;
						vertex       <= pend_q;
						last         <= 1'b0;
						pend_q       <= w;
						visited_q[w] <= 1'b1;
						depth_q      <= depth_q + (VW+1)'(1);
						state_q      <= S_HEAD;
					end else begin
						top_q   <= nx;
						state_q <= S_TOP;
					end
				end
				S_POP: begin
					top_q   <= s_rdata;
					state_q <= S_TOP;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
